[rtl/b2d_pkg.sv]
// Shared constants and types of the binary to decimal ASCII converter.
`timescale 1ns / 1ps
package b2d_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int BCD_W       = 4 * MAX_DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W       = $clog2(MAX_DIGITS + 1);
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [BCD_W-1:0] bcd_t;

  // One queued conversion job.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_zero;
  } q_entry_t;

  // Queue occupancy as seen by the top level.
  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } q_status_t;

endpackage

[rtl/b2d_front.sv]
// Input stage: accepts values, flags zero values and queues them in a two-entry FIFO.
`timescale 1ns / 1ps
module b2d_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [b2d_pkg::VALUE_WIDTH-1:0]   in_value,
  output logic                              q_valid,
  output b2d_pkg::q_entry_t                 q_entry,
  input  logic                              q_pop,
  output b2d_pkg::q_status_t                q_status
);

  b2d_pkg::q_entry_t mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              push;
  logic              pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem_r[rd_ptr_r];

  assign q_status.full  = in_stall;
  assign q_status.count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].value   <= in_value;
      mem_r[wr_ptr_r].is_zero <= (in_value == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/b2d_dabble.sv]
// Iterative shift-add-3 converter: one input bit per cycle into a BCD register.
`timescale 1ns / 1ps
module b2d_dabble (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  b2d_pkg::q_entry_t      q_entry,
  output logic                   q_pop,
  output logic                   bcd_valid,
  output b2d_pkg::bcd_t          bcd,
  input  logic                   bcd_ready
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dstate_t;

  dstate_t                          state_r;
  logic [b2d_pkg::VALUE_WIDTH-1:0]  sh_r;
  b2d_pkg::bcd_t                    bcd_r;
  logic [b2d_pkg::CNT_W-1:0]        cnt_r;
  b2d_pkg::bcd_t                    adj;
  b2d_pkg::bcd_t                    bcd_nxt;

  // Correct every digit of five or more before the shift doubles it.
  always_comb begin
    for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // The carry out of the top digit falls off, which keeps the value modulo
  // the register's decimal range.
  assign bcd_nxt = {adj[b2d_pkg::BCD_W-2:0], sh_r[b2d_pkg::VALUE_WIDTH-1]};

  assign q_pop     = (state_r == D_IDLE) && q_valid;
  assign bcd_valid = (state_r == D_DONE);
  assign bcd       = bcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (q_valid) begin
            sh_r  <= q_entry.value;
            bcd_r <= '0;
            cnt_r <= b2d_pkg::CNT_W'(b2d_pkg::VALUE_WIDTH);
            if (q_entry.is_zero) begin
              state_r <= D_DONE;
            end else begin
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          bcd_r <= bcd_nxt;
          sh_r  <= {sh_r[b2d_pkg::VALUE_WIDTH-2:0], 1'b0};
          cnt_r <= cnt_r - b2d_pkg::CNT_W'(1);
          if (cnt_r == b2d_pkg::CNT_W'(1)) begin
            state_r <= D_DONE;
          end
        end
        D_DONE: begin
          if (bcd_ready) begin
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

[rtl/b2d_emit.sv]
// Output sequencer: skips leading zero digits and sends ASCII characters, top digit first.
`timescale 1ns / 1ps
module b2d_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              bcd_valid,
  input  b2d_pkg::bcd_t                     bcd,
  output logic                              bcd_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                              out_last
);

  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_SEND
  } estate_t;

  estate_t                     state_r;
  b2d_pkg::bcd_t               bcd_r;
  logic [b2d_pkg::REM_W-1:0]   rem_r;
  logic                        out_valid_r;
  logic [b2d_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_last_r;
  logic [3:0]                  top;
  logic [3:0]                  next_top;

  assign top       = bcd_r[b2d_pkg::BCD_W-1 -: 4];
  assign next_top  = bcd_r[b2d_pkg::BCD_W-5 -: 4];
  assign bcd_ready = (state_r == E_IDLE);

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (bcd_valid) begin
            bcd_r   <= bcd;
            rem_r   <= b2d_pkg::REM_W'(b2d_pkg::MAX_DIGITS);
            state_r <= E_SKIP;
          end
        end
        E_SKIP: begin
          // The lowest digit is always sent, even when it is zero.
          if (top != 4'd0 || rem_r == b2d_pkg::REM_W'(1)) begin
            out_valid_r <= 1'b1;
            out_char_r  <= b2d_pkg::ASCII_ZERO + {2'b00, top};
            out_last_r  <= (rem_r == b2d_pkg::REM_W'(1));
            state_r     <= E_SEND;
          end else begin
            bcd_r <= {bcd_r[b2d_pkg::BCD_W-5:0], 4'd0};
            rem_r <= rem_r - b2d_pkg::REM_W'(1);
          end
        end
        E_SEND: begin
          if (!out_stall) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= E_IDLE;
            end else begin
              bcd_r      <= {bcd_r[b2d_pkg::BCD_W-5:0], 4'd0};
              rem_r      <= rem_r - b2d_pkg::REM_W'(1);
              out_char_r <= b2d_pkg::ASCII_ZERO + {2'b00, next_top};
              out_last_r <= (rem_r == b2d_pkg::REM_W'(2));
            end
          end
        end
        default: begin
          state_r     <= E_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/binary_to_decimal_ascii_core.sv]
// Top level of the binary to decimal ASCII converter.
//
// Input channel: in_valid / in_stall / in_value carry one unsigned binary
// value per transaction. Output channel: out_valid / out_stall carry one ASCII
// digit per transaction (out_digit_char, '0' to '9'), most significant first,
// with leading zeros dropped; out_last marks the final digit of a value, and
// zero gives the single character '0'.
// A two-entry queue takes values while the converter is busy; in_stall rises
// only when both entries are held.
// Path: a value passes through the queue, the shift-add-3 loop (one input
// bit per cycle; a zero value skips it), a hand-over to the sequencer, and
// the skipping of each leading zero digit before the first character.
// Characters then follow one per cycle while out_stall is low.
// Sending the digits of one value overlaps the conversion of the next value.
// A stall on the output holds the current character and, once the queue
// fills, the input. Reset empties the queue and returns both engines to idle.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [b2d_pkg::VALUE_WIDTH-1:0]   in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                              out_last
);

  logic               q_valid;
  b2d_pkg::q_entry_t  q_entry;
  logic               q_pop;
  b2d_pkg::q_status_t q_status;
  logic               bcd_valid;
  b2d_pkg::bcd_t      bcd;
  logic               bcd_ready;

  b2d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .q_status (q_status)
  );

  b2d_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .bcd_valid (bcd_valid),
    .bcd       (bcd),
    .bcd_ready (bcd_ready)
  );

  b2d_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .bcd_valid      (bcd_valid),
    .bcd            (bcd),
    .bcd_ready      (bcd_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  // The queue never holds more than its two entries, and it reports full
  // exactly when both are held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_status.count != 2'd3) && (q_status.full == (q_status.count == 2'd2)))
    else $error("queue count out of range");

  // A finished conversion waits until the sequencer takes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    bcd_valid && !bcd_ready |=> bcd_valid)
    else $error("converted value dropped before hand-over");

  // The channel goes quiet right after the final digit of a value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_stall |=> !out_valid)
    else $error("output valid after final digit");

  // Every character sent is a decimal digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("non-decimal character sent");

endmodule
